// ===== hw/rtl/cbcr_pkg.sv =====
// ----------------------------------------------------------------------------
// cbcr_pkg: shared types and constants for the circle/box collision resolver
// Widths of the fixed-point fields, shape and kind codes, and the structures
// that travel down the pipeline between its units.
// ----------------------------------------------------------------------------
package cbcr_pkg;

    localparam int POS_W      = 24;   // signed positions and displacements
    localparam int SIZE_W     = 23;   // unsigned radius, width, height
    localparam int KIND_W     = 2;
    localparam int SUM_W      = 24;   // sum of two sizes
    localparam int DIFF_W     = 25;   // difference of two positions
    localparam int VEC_W      = 27;   // doubled and clamped offsets
    localparam int MAG_W      = 26;   // magnitude of a VEC_W offset
    localparam int SQ_W       = 52;   // square of a magnitude
    localparam int LEN_W      = 53;   // sum of two squares
    localparam int THR_SQ_W   = 48;   // squared hit threshold
    localparam int RAD_W      = 48;   // square root input
    localparam int ROOT_W     = 24;   // square root output
    localparam int PEN_W      = 24;   // penetration depth
    localparam int DEN_W      = 25;   // distance times share divisor
    localparam int PROD_W     = 49;   // offset magnitude times penetration
    localparam int DIV_N_W    = 50;   // rounded dividend
    localparam int DIV_D_W    = 26;   // rounded divisor
    localparam int DIV_Q_W    = 26;   // quotient bits
    localparam int RES_W      = 27;   // displacement before saturation

    localparam int IN_DATA_W  = 192;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 96;

    localparam logic SHAPE_CIRCLE = 1'b0;
    localparam logic SHAPE_BOX    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_STATIC = 2'd1;
    localparam int                KIND_TRIG_BIT = 1;

    localparam logic [1:0] SHARE_NONE  = 2'd0;
    localparam logic [1:0] SHARE_WHOLE = 2'd1;
    localparam logic [1:0] SHARE_HALF  = 2'd2;

    localparam logic signed [RES_W-1:0] OUT_MAX = RES_W'((1 <<< (POS_W - 1)) - 1);
    localparam logic signed [RES_W-1:0] OUT_MIN = -RES_W'(1 <<< (POS_W - 1));

    typedef enum logic [1:0] {
        CLS_CC,     // two circles
        CLS_CB,     // circle and box
        CLS_BB      // two boxes
    } cls_t;

    typedef enum logic [1:0] {
        AX_UP,
        AX_RIGHT,
        AX_DOWN,
        AX_LEFT
    } axis_t;

    typedef struct packed {
        logic              shape;
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [KIND_W-1:0] kind;
    } shape_t;

    // Travels alongside the square root.
    typedef struct packed {
        logic                     hit;
        cls_t                     cls;
        logic                     a_circ;
        logic [1:0]               dl;
        logic [1:0]               dr;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [SUM_W-1:0]         t;
        axis_t                    axis;
    } side_t;

    // Travels alongside the divider.
    typedef struct packed {
        logic             hit;
        cls_t             cls;
        logic             a_circ;
        logic [1:0]       dl;
        logic [1:0]       dr;
        logic             sx;
        logic             sy;
        axis_t            axis;
        logic [PEN_W-1:0] p;
    } post_t;

    // Share divisors {left, right}: none, whole push, or half push.
    function automatic logic [3:0] shares(input logic [KIND_W-1:0] kl,
                                          input logic [KIND_W-1:0] kr);
        logic sl;
        logic sr;
        sl = (kl == KIND_STATIC);
        sr = (kr == KIND_STATIC);
        if (kl[KIND_TRIG_BIT] || kr[KIND_TRIG_BIT] || (sl && sr))
            return {SHARE_NONE, SHARE_NONE};
        else if (sl != sr)
            return {sl ? SHARE_NONE : SHARE_WHOLE, sr ? SHARE_NONE : SHARE_WHOLE};
        else
            return {SHARE_HALF, SHARE_HALF};
    endfunction

endpackage

// ===== hw/rtl/cbcr_front.sv =====
// ----------------------------------------------------------------------------
// cbcr_front: geometry front end
// Four stages: differences, clamping and box test, squares and push axis,
// then the hit compares and the square root operand.
// ----------------------------------------------------------------------------
module cbcr_front
    import cbcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  shape_t            in_a,
    input  shape_t            in_b,
    output logic              out_valid,
    output logic [RAD_W-1:0]  out_rad,
    output side_t             out_side
);

    typedef struct packed {
        cls_t                     cls;
        logic                     a_circ;
        logic [1:0]               dl;
        logic [1:0]               dr;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [SUM_W-1:0]         sw;
        logic [SUM_W-1:0]         sh;
        logic [SIZE_W-1:0]        r;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
    } f1_t;

    typedef struct packed {
        cls_t                    cls;
        logic                    a_circ;
        logic [1:0]              dl;
        logic [1:0]              dr;
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic [SUM_W-1:0]        t;
        logic                    hit_bb;
    } f2_t;

    typedef struct packed {
        cls_t                     cls;
        logic                     a_circ;
        logic [1:0]               dl;
        logic [1:0]               dr;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [SUM_W-1:0]         t;
        logic [SQ_W-1:0]          sqx;
        logic [SQ_W-1:0]          sqy;
        logic [THR_SQ_W-1:0]      tt;
        logic                     in_box;
        axis_t                    axis;
        logic                     hit_bb;
    } f3_t;

    f1_t   f1_next, f1_reg;
    f2_t   f2_next, f2_reg;
    f3_t   f3_next, f3_reg;
    side_t f4_next, f4_reg;
    logic [RAD_W-1:0] rad_next, rad_reg;
    logic  v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1: shape class, center differences, size sums, shares.
    always_comb
    begin
        logic a_circ;
        logic b_circ;
        a_circ = (in_a.shape == SHAPE_CIRCLE);
        b_circ = (in_b.shape == SHAPE_CIRCLE);
        if (a_circ && b_circ)
            f1_next.cls = CLS_CC;
        else if (a_circ != b_circ)
            f1_next.cls = CLS_CB;
        else
            f1_next.cls = CLS_BB;
        f1_next.a_circ = a_circ;
        f1_next.dx = $signed({in_a.x[POS_W-1], in_a.x}) - $signed({in_b.x[POS_W-1], in_b.x});
        f1_next.dy = $signed({in_a.y[POS_W-1], in_a.y}) - $signed({in_b.y[POS_W-1], in_b.y});
        f1_next.sw = {1'b0, in_a.size_x} + {1'b0, in_b.size_x};
        f1_next.sh = {1'b0, in_a.size_y} + {1'b0, in_b.size_y};
        f1_next.r  = a_circ ? in_a.size_x : in_b.size_x;
        f1_next.w  = a_circ ? in_b.size_x : in_a.size_x;
        f1_next.h  = a_circ ? in_b.size_y : in_a.size_y;
        // For a circle and a box the left share belongs to the circle.
        if (!a_circ && b_circ)
            {f1_next.dl, f1_next.dr} = shares(in_b.kind, in_a.kind);
        else
            {f1_next.dl, f1_next.dr} = shares(in_a.kind, in_b.kind);
    end

    // Stage 2: clamp the doubled offset to the box, and the box pair test.
    always_comb
    begin
        logic signed [VEC_W-1:0] ex;
        logic signed [VEC_W-1:0] ey;
        logic signed [VEC_W-1:0] wl;
        logic signed [VEC_W-1:0] hl;
        logic signed [VEC_W-1:0] clx;
        logic signed [VEC_W-1:0] cly;
        logic [DIFF_W-1:0]       mx;
        logic [DIFF_W-1:0]       my;
        ex = $signed({f1_reg.dx[DIFF_W-1], f1_reg.dx, 1'b0});
        ey = $signed({f1_reg.dy[DIFF_W-1], f1_reg.dy, 1'b0});
        if (!f1_reg.a_circ)
        begin
            ex = -ex;
            ey = -ey;
        end
        wl = $signed({{(VEC_W-SIZE_W){1'b0}}, f1_reg.w});
        hl = $signed({{(VEC_W-SIZE_W){1'b0}}, f1_reg.h});
        if (ex < -wl)
            clx = -wl;
        else if (ex > wl)
            clx = wl;
        else
            clx = ex;
        if (ey < -hl)
            cly = -hl;
        else if (ey > hl)
            cly = hl;
        else
            cly = ey;
        mx = f1_reg.dx[DIFF_W-1] ? DIFF_W'(-f1_reg.dx) : DIFF_W'(f1_reg.dx);
        my = f1_reg.dy[DIFF_W-1] ? DIFF_W'(-f1_reg.dy) : DIFF_W'(f1_reg.dy);

        f2_next.cls    = f1_reg.cls;
        f2_next.a_circ = f1_reg.a_circ;
        f2_next.dl     = f1_reg.dl;
        f2_next.dr     = f1_reg.dr;
        f2_next.hit_bb = ({mx, 1'b0} < {2'b00, f1_reg.sw}) && ({my, 1'b0} < {2'b00, f1_reg.sh});
        if (f1_reg.cls == CLS_CB)
        begin
            f2_next.vx = clx - ex;
            f2_next.vy = cly - ey;
            f2_next.t  = {f1_reg.r, 1'b0};
        end
        else
        begin
            f2_next.vx = $signed({{(VEC_W-DIFF_W){f1_reg.dx[DIFF_W-1]}}, f1_reg.dx});
            f2_next.vy = $signed({{(VEC_W-DIFF_W){f1_reg.dy[DIFF_W-1]}}, f1_reg.dy});
            f2_next.t  = f1_reg.sw;
        end
    end

    // Stage 3: squares and the best-matching push axis.
    always_comb
    begin
        logic [VEC_W-1:0] ax;
        logic [VEC_W-1:0] ay;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic             gx_pos;
        logic             gy_pos;
        ax = f2_reg.vx[VEC_W-1] ? VEC_W'(-f2_reg.vx) : VEC_W'(f2_reg.vx);
        ay = f2_reg.vy[VEC_W-1] ? VEC_W'(-f2_reg.vy) : VEC_W'(f2_reg.vy);
        mx = ax[MAG_W-1:0];
        my = ay[MAG_W-1:0];
        gx_pos = !f2_reg.vx[VEC_W-1] && (f2_reg.vx != '0);
        gy_pos = !f2_reg.vy[VEC_W-1] && (f2_reg.vy != '0);

        f3_next.cls    = f2_reg.cls;
        f3_next.a_circ = f2_reg.a_circ;
        f3_next.dl     = f2_reg.dl;
        f3_next.dr     = f2_reg.dr;
        f3_next.dx     = f2_reg.vx[DIFF_W-1:0];
        f3_next.dy     = f2_reg.vy[DIFF_W-1:0];
        f3_next.t      = f2_reg.t;
        f3_next.sqx    = SQ_W'(mx) * SQ_W'(mx);
        f3_next.sqy    = SQ_W'(my) * SQ_W'(my);
        f3_next.tt     = THR_SQ_W'(f2_reg.t) * THR_SQ_W'(f2_reg.t);
        f3_next.in_box = (f2_reg.vx == '0) && (f2_reg.vy == '0);
        f3_next.hit_bb = f2_reg.hit_bb;
        if (gy_pos && (my >= mx))
            f3_next.axis = AX_UP;
        else if (gx_pos && (!f2_reg.vy[VEC_W-1] || (mx >= my)))
            f3_next.axis = AX_RIGHT;
        else if (f2_reg.vy[VEC_W-1] && (my >= mx))
            f3_next.axis = AX_DOWN;
        else
            f3_next.axis = AX_LEFT;
    end

    // Stage 4: distance compare, hit, and gating of the push.
    always_comb
    begin
        logic [LEN_W-1:0] len;
        logic             lt;
        logic             push;
        len  = {1'b0, f3_reg.sqx} + {1'b0, f3_reg.sqy};
        lt   = len < LEN_W'(f3_reg.tt);
        push = lt && ((f3_reg.cls == CLS_CC) || ((f3_reg.cls == CLS_CB) && !f3_reg.in_box));

        case (f3_reg.cls)
            CLS_CC:  f4_next.hit = lt;
            CLS_CB:  f4_next.hit = lt || f3_reg.in_box;
            default: f4_next.hit = f3_reg.hit_bb;
        endcase
        f4_next.cls    = f3_reg.cls;
        f4_next.a_circ = f3_reg.a_circ;
        f4_next.dl     = push ? f3_reg.dl : SHARE_NONE;
        f4_next.dr     = push ? f3_reg.dr : SHARE_NONE;
        f4_next.dx     = f3_reg.dx;
        f4_next.dy     = f3_reg.dy;
        f4_next.t      = f3_reg.t;
        f4_next.axis   = f3_reg.axis;
        rad_next       = push ? len[RAD_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg  <= f1_next;
            f2_reg  <= f2_next;
            f3_reg  <= f3_next;
            f4_reg  <= f4_next;
            rad_reg <= rad_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_rad   = rad_reg;
    assign out_side  = f4_reg;

endmodule

// ===== hw/rtl/cbcr_sqrt.sv =====
// ----------------------------------------------------------------------------
// cbcr_sqrt: pipelined integer square root
// One result bit per stage, floor of the root, side data carried along.
// ----------------------------------------------------------------------------
module cbcr_sqrt
    import cbcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    localparam int REM_W = ROOT_W + 2;

    logic [REM_W-1:0]  rem_next  [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [RAD_W-1:0]  rest_next [ROOT_W];
    logic [RAD_W-1:0]  rest_reg  [ROOT_W];
    side_t             side_reg  [ROOT_W];
    logic              vld_reg   [ROOT_W];

    always_comb
    begin
        logic [REM_W-1:0]  pr;
        logic [ROOT_W-1:0] pt;
        logic [RAD_W-1:0]  ps;
        logic [REM_W+1:0]  sh;
        logic [REM_W+1:0]  trial;
        for (int i = 0; i < ROOT_W; i++)
        begin
            if (i == 0)
            begin
                pr = '0;
                pt = '0;
                ps = in_rad;
            end
            else
            begin
                pr = rem_reg[i-1];
                pt = root_reg[i-1];
                ps = rest_reg[i-1];
            end
            sh    = {pr, ps[RAD_W-1 -: 2]};
            trial = {2'b00, pt, 2'b01};
            if (sh >= trial)
            begin
                rem_next[i]  = REM_W'(sh - trial);
                root_next[i] = {pt[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = sh[REM_W-1:0];
                root_next[i] = {pt[ROOT_W-2:0], 1'b0};
            end
            rest_next[i] = {ps[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROOT_W; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < ROOT_W; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < ROOT_W; i++)
                side_reg[i] <= side_reg[i-1];
            for (int i = 0; i < ROOT_W; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rest_reg[i] <= rest_next[i];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ===== hw/rtl/cbcr_div.sv =====
// ----------------------------------------------------------------------------
// cbcr_div: pipelined two-lane restoring divider
// Both lanes share one divisor; one quotient bit per stage.
// ----------------------------------------------------------------------------
module cbcr_div
    import cbcr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DIV_N_W-1:0] in_num_x,
    input  logic [DIV_N_W-1:0] in_num_y,
    input  logic [DIV_D_W-1:0] in_den,
    input  post_t              in_post,
    output logic               out_valid,
    output logic [DIV_Q_W-1:0] out_q_x,
    output logic [DIV_Q_W-1:0] out_q_y,
    output post_t              out_post
);

    localparam int REM_W = DIV_D_W + 1;
    localparam int TOP_W = DIV_N_W - DIV_Q_W;

    logic [REM_W-1:0]   rx_next [DIV_Q_W];
    logic [REM_W-1:0]   rx_reg  [DIV_Q_W];
    logic [REM_W-1:0]   ry_next [DIV_Q_W];
    logic [REM_W-1:0]   ry_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0] qx_next [DIV_Q_W];
    logic [DIV_Q_W-1:0] qx_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0] qy_next [DIV_Q_W];
    logic [DIV_Q_W-1:0] qy_reg  [DIV_Q_W];
    logic [DIV_D_W-1:0] d_reg   [DIV_Q_W];
    post_t              post_reg[DIV_Q_W];
    logic               vld_reg [DIV_Q_W];

    // Each lane word holds the unused dividend bits on top and the
    // quotient bits that have been found below them.
    always_comb
    begin
        logic [REM_W-1:0]   prx;
        logic [REM_W-1:0]   pry;
        logic [DIV_Q_W-1:0] pqx;
        logic [DIV_Q_W-1:0] pqy;
        logic [DIV_D_W-1:0] pd;
        logic [REM_W-1:0]   shx;
        logic [REM_W-1:0]   shy;
        for (int i = 0; i < DIV_Q_W; i++)
        begin
            if (i == 0)
            begin
                prx = REM_W'(in_num_x[DIV_N_W-1 -: TOP_W]);
                pry = REM_W'(in_num_y[DIV_N_W-1 -: TOP_W]);
                pqx = in_num_x[DIV_Q_W-1:0];
                pqy = in_num_y[DIV_Q_W-1:0];
                pd  = in_den;
            end
            else
            begin
                prx = rx_reg[i-1];
                pry = ry_reg[i-1];
                pqx = qx_reg[i-1];
                pqy = qy_reg[i-1];
                pd  = d_reg[i-1];
            end
            shx = {prx[REM_W-2:0], pqx[DIV_Q_W-1]};
            shy = {pry[REM_W-2:0], pqy[DIV_Q_W-1]};
            if (shx >= {1'b0, pd})
            begin
                rx_next[i] = shx - {1'b0, pd};
                qx_next[i] = {pqx[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rx_next[i] = shx;
                qx_next[i] = {pqx[DIV_Q_W-2:0], 1'b0};
            end
            if (shy >= {1'b0, pd})
            begin
                ry_next[i] = shy - {1'b0, pd};
                qy_next[i] = {pqy[DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                ry_next[i] = shy;
                qy_next[i] = {pqy[DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_Q_W; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DIV_Q_W; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0]    <= in_den;
            post_reg[0] <= in_post;
            for (int i = 1; i < DIV_Q_W; i++)
            begin
                d_reg[i]    <= d_reg[i-1];
                post_reg[i] <= post_reg[i-1];
            end
            for (int i = 0; i < DIV_Q_W; i++)
            begin
                rx_reg[i] <= rx_next[i];
                ry_reg[i] <= ry_next[i];
                qx_reg[i] <= qx_next[i];
                qy_reg[i] <= qy_next[i];
            end
        end
    end

    assign out_valid = vld_reg[DIV_Q_W-1];
    assign out_q_x   = qx_reg[DIV_Q_W-1];
    assign out_q_y   = qy_reg[DIV_Q_W-1];
    assign out_post  = post_reg[DIV_Q_W-1];

endmodule

// ===== hw/rtl/circle_box_collision_resolve.sv =====
// 4 geometry, 24 square root, 3 scaling and 26 divider stages and 1 output register
// lie between an accepted request and its result on the master side. Throughput:
// one request per cycle while the skid register is empty; the one-bit-per-stage
// square root and divider are fully pipelined. A skid register behind the output
// absorbs one result when the master side stalls. Reset clears all valid bits.
// ----------------------------------------------------------------------------
// circle_box_collision_resolve: overlap test and push-out for two 2D shapes
// Each request carries two shapes (circle or axis-aligned box) and returns
// a hit flag and the displacement of each shape, rounded and saturated.
// ----------------------------------------------------------------------------
module circle_box_collision_resolve
    import cbcr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // From bit 0: a_x[24], a_y[24], a_size_x[23], a_size_y[23],
    // b_x[24], b_y[24], b_size_x[23], b_size_y[23], zero fill[4].
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // From bit 0: a_type[1], a_kind[2], b_type[1], b_kind[2].
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // From bit 0: a_dx[24], a_dy[24], b_dx[24], b_dy[24].
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Bit 0: hit.
    output logic                  m_axis_tuser
);

    // The whole pipeline moves together; it only halts while the skid
    // register holds a result that the master side has not taken yet.
    logic adv;

    shape_t sa;
    shape_t sb;

    logic             fr_valid;
    logic [RAD_W-1:0] fr_rad;
    side_t            fr_side;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    // Scaling stages between the square root and the divider.
    logic               p1_valid_reg, p2_valid_reg, p3_valid_reg;
    post_t              p1_post_next, p1_post_reg, p2_post_reg, p3_post_reg;
    logic [DEN_W-1:0]   p1_den_next, p1_den_reg, p2_den_reg;
    logic [DIFF_W-1:0]  p1_mx_next, p1_mx_reg, p1_my_next, p1_my_reg;
    logic [PROD_W-1:0]  p2_px_reg, p2_py_reg;
    logic [DIV_N_W-1:0] p3_nx_reg, p3_ny_reg;
    logic [DIV_D_W-1:0] p3_d_reg;

    logic               dv_valid;
    logic [DIV_Q_W-1:0] dv_qx;
    logic [DIV_Q_W-1:0] dv_qy;
    post_t              dv_post;

    logic [OUT_DATA_W-1:0] res_data;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_hit_reg;
    logic                  sk_valid_reg;
    logic [OUT_DATA_W-1:0] sk_data_reg;
    logic                  sk_hit_reg;

    assign adv           = !sk_valid_reg;
    assign s_axis_tready = adv;

    assign sa.shape  = s_axis_tuser[0];
    assign sa.kind   = s_axis_tuser[2:1];
    assign sb.shape  = s_axis_tuser[3];
    assign sb.kind   = s_axis_tuser[5:4];
    assign sa.x      = s_axis_tdata[23:0];
    assign sa.y      = s_axis_tdata[47:24];
    assign sa.size_x = s_axis_tdata[70:48];
    assign sa.size_y = s_axis_tdata[93:71];
    assign sb.x      = s_axis_tdata[117:94];
    assign sb.y      = s_axis_tdata[141:118];
    assign sb.size_x = s_axis_tdata[164:142];
    assign sb.size_y = s_axis_tdata[187:165];

    cbcr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s_axis_tvalid),
        .in_a      (sa),
        .in_b      (sb),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_side  (fr_side)
    );

    cbcr_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Penetration, the divisor for the share, and the offset magnitudes.
    // Two circles with coincident centers get no push.
    always_comb
    begin
        logic [1:0] dl;
        logic [1:0] dr;
        logic [1:0] sh;
        if ((sq_side.cls == CLS_CC) && (sq_root == '0))
        begin
            dl = SHARE_NONE;
            dr = SHARE_NONE;
        end
        else
        begin
            dl = sq_side.dl;
            dr = sq_side.dr;
        end
        sh = (dl != SHARE_NONE) ? dl : dr;
        case (sh)
            SHARE_WHOLE: p1_den_next = {1'b0, sq_root};
            SHARE_HALF:  p1_den_next = {sq_root, 1'b0};
            default:     p1_den_next = DEN_W'(1);
        endcase
        p1_post_next.hit    = sq_side.hit;
        p1_post_next.cls    = sq_side.cls;
        p1_post_next.a_circ = sq_side.a_circ;
        p1_post_next.dl     = dl;
        p1_post_next.dr     = dr;
        p1_post_next.sx     = sq_side.dx[DIFF_W-1];
        p1_post_next.sy     = sq_side.dy[DIFF_W-1];
        p1_post_next.axis   = sq_side.axis;
        p1_post_next.p      = PEN_W'(sq_side.t - sq_root);
        p1_mx_next = sq_side.dx[DIFF_W-1] ? DIFF_W'(-sq_side.dx) : DIFF_W'(sq_side.dx);
        p1_my_next = sq_side.dy[DIFF_W-1] ? DIFF_W'(-sq_side.dy) : DIFF_W'(sq_side.dy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= sq_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // Round to nearest with ties away from zero: (2m + den) / (2 den).
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_post_reg <= p1_post_next;
            p1_den_reg  <= p1_den_next;
            p1_mx_reg   <= p1_mx_next;
            p1_my_reg   <= p1_my_next;

            p2_post_reg <= p1_post_reg;
            p2_den_reg  <= p1_den_reg;
            p2_px_reg   <= PROD_W'(p1_mx_reg) * PROD_W'(p1_post_reg.p);
            p2_py_reg   <= PROD_W'(p1_my_reg) * PROD_W'(p1_post_reg.p);

            p3_post_reg <= p2_post_reg;
            p3_nx_reg   <= {p2_px_reg, 1'b0} + DIV_N_W'(p2_den_reg);
            p3_ny_reg   <= {p2_py_reg, 1'b0} + DIV_N_W'(p2_den_reg);
            p3_d_reg    <= {p2_den_reg, 1'b0};
        end
    end

    cbcr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p3_valid_reg),
        .in_num_x  (p3_nx_reg),
        .in_num_y  (p3_ny_reg),
        .in_den    (p3_d_reg),
        .in_post   (p3_post_reg),
        .out_valid (dv_valid),
        .out_q_x   (dv_qx),
        .out_q_y   (dv_qy),
        .out_post  (dv_post)
    );

    function automatic logic [POS_W-1:0] sat(input logic signed [RES_W-1:0] v);
        if (v > OUT_MAX)
            return OUT_MAX[POS_W-1:0];
        else if (v < OUT_MIN)
            return OUT_MIN[POS_W-1:0];
        else
            return v[POS_W-1:0];
    endfunction

    function automatic logic signed [RES_W-1:0] pen_share(input logic [PEN_W-1:0] p,
                                                          input logic [1:0] d);
        logic [PEN_W:0] h;
        logic [PEN_W:0] q;
        h = {1'b0, p} + (PEN_W + 1)'(1);
        q = {1'b0, p} + (PEN_W + 1)'(2);
        case (d)
            SHARE_WHOLE: return $signed(RES_W'(h[PEN_W:1]));
            SHARE_HALF:  return $signed(RES_W'(q[PEN_W:2]));
            default:     return '0;
        endcase
    endfunction

    // Final selection of the four displacement components.
    always_comb
    begin
        logic signed [RES_W-1:0] qx;
        logic signed [RES_W-1:0] qy;
        logic signed [RES_W-1:0] ml;
        logic signed [RES_W-1:0] mr;
        logic signed [RES_W-1:0] cdx, cdy, odx, ody;
        logic signed [RES_W-1:0] adx, ady, bdx, bdy;
        qx = $signed({1'b0, dv_qx});
        qy = $signed({1'b0, dv_qy});
        if (dv_post.sx)
            qx = -qx;
        if (dv_post.sy)
            qy = -qy;
        ml  = pen_share(dv_post.p, dv_post.dl);
        mr  = pen_share(dv_post.p, dv_post.dr);
        cdx = '0;
        cdy = '0;
        odx = '0;
        ody = '0;
        // The circle moves against the axis, the box along it.
        case (dv_post.axis)
            AX_UP:
            begin
                cdy = -ml;
                ody = mr;
            end
            AX_RIGHT:
            begin
                cdx = -ml;
                odx = mr;
            end
            AX_DOWN:
            begin
                cdy = ml;
                ody = -mr;
            end
            default:
            begin
                cdx = ml;
                odx = -mr;
            end
        endcase
        if (dv_post.cls == CLS_CC)
        begin
            adx = (dv_post.dl != SHARE_NONE) ? qx : '0;
            ady = (dv_post.dl != SHARE_NONE) ? qy : '0;
            bdx = (dv_post.dr != SHARE_NONE) ? -qx : '0;
            bdy = (dv_post.dr != SHARE_NONE) ? -qy : '0;
        end
        else if (dv_post.a_circ)
        begin
            adx = cdx;
            ady = cdy;
            bdx = odx;
            bdy = ody;
        end
        else
        begin
            adx = odx;
            ady = ody;
            bdx = cdx;
            bdy = cdy;
        end
        res_data = {sat(bdy), sat(bdx), sat(ady), sat(adx)};
    end

    // Output register with a one-entry skid buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end
        else if (sk_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_valid_reg <= 1'b1;
                sk_valid_reg  <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_axis_tready)
            out_valid_reg <= dv_valid;
        else if (dv_valid)
            sk_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (sk_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_data_reg <= sk_data_reg;
                out_hit_reg  <= sk_hit_reg;
            end
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_data_reg <= res_data;
            out_hit_reg  <= dv_post.hit;
        end
        else
        begin
            sk_data_reg <= res_data;
            sk_hit_reg  <= dv_post.hit;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_hit_reg;

endmodule
